// ----- rtl/core/sv39_page_walk_lookup_update_macros.svh -----
// Assertion macros shared by the Sv39 walker RTL.
// Used by sv39pw_step and sv39pw_outq; no other dependencies.
`ifndef SV39_PAGE_WALK_LOOKUP_UPDATE_MACROS_SVH
`define SV39_PAGE_WALK_LOOKUP_UPDATE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SV39PW_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sv39pw check failed");

// Next-cycle implication, disabled while reset is low.
`define SV39PW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sv39pw check failed");

`endif

// ----- rtl/core/sv39pw_pkg.sv -----
// Types, codes and helpers for the Sv39 page walker.
// No dependencies; used by every other file of the block but the assertion macro header.
`default_nettype none

package sv39pw_pkg;

  localparam int unsigned VA_W   = 39;
  localparam int unsigned PPN_W  = 44;
  localparam int unsigned PERM_W = 10;
  localparam int unsigned PA_W   = 56;
  localparam int unsigned PTE_W  = 64;
  localparam int unsigned IDX_W  = 9;

  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // input opcodes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_RESP   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISSING   = 2'd1;
  localparam logic [1:0] ST_SUPERPAGE = 2'd2;
  localparam logic [1:0] ST_LEAF_INV  = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_L2   = 4'b0010,
    PH_L1   = 4'b0100,
    PH_LEAF = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [VA_W-1:0]   virt_addr;
    logic [PPN_W-1:0]  target_ppn;
    logic [PERM_W-1:0] perm_bits;
    logic [PTE_W-1:0]  read_data;
  } item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PA_W-1:0]  phys_addr;
    logic [PTE_W-1:0] write_data;
    logic [1:0]       status;
    logic             last;
  } res_t;

  // results pushed into the output queue in one cycle (0..2)
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // entry address: table base plus 8 * index
  function automatic logic [PA_W-1:0] slot_addr(input logic [PA_W-1:0] base,
                                                input logic [IDX_W-1:0] idx);
    slot_addr = base + {{(PA_W-IDX_W-3){1'b0}}, idx, 3'b000};
  endfunction

  // base of the next table from a non-leaf entry
  function automatic logic [PA_W-1:0] next_base(input logic [PTE_W-1:0] pte);
    next_base = {pte[PPN_W+9:10], 12'h000};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sv39pw_req_if.sv -----
// Request / memory response channel of the Sv39 walker.
// Depends on sv39pw_pkg for field widths.
`default_nettype none

interface sv39pw_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     opcode;
  logic [sv39pw_pkg::VA_W-1:0]    virt_addr;
  logic [sv39pw_pkg::PPN_W-1:0]   target_ppn;
  logic [sv39pw_pkg::PERM_W-1:0]  perm_bits;
  logic [sv39pw_pkg::PTE_W-1:0]   read_data;

  modport source (output valid, opcode, virt_addr, target_ppn, perm_bits, read_data,
                  input ready);
  modport sink (input valid, opcode, virt_addr, target_ppn, perm_bits, read_data,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sv39pw_res_if.sv -----
// Result channel of the Sv39 walker: memory requests and walk completions.
// Depends on sv39pw_pkg for field widths.
`default_nettype none

interface sv39pw_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [sv39pw_pkg::PA_W-1:0]   phys_addr;
  logic [sv39pw_pkg::PTE_W-1:0]  write_data;
  logic [1:0]                    status;
  logic                          last;

  modport source (output valid, kind, phys_addr, write_data, status, last,
                  input ready);
  modport sink (input valid, kind, phys_addr, write_data, status, last,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sv39pw_cfg_if.sv -----
// Configuration write channel: root table PPN.
// Depends on sv39pw_pkg for the data width.
`default_nettype none

interface sv39pw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sv39pw_pkg::PPN_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sv39pw_step.sv -----
// Walker core: input item register, walk state and per-item result logic.
// Depends on sv39pw_pkg and the assertion macro header.
`default_nettype none
`include "sv39_page_walk_lookup_update_macros.svh"

module sv39pw_step (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire sv39pw_pkg::item_t            in_item_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [sv39pw_pkg::PPN_W-1:0] cfg_data_i,
  input  wire logic                         room_i,
  output sv39pw_pkg::push_t                 push_o
);

  logic                           item_vld_q, item_vld_d;
  sv39pw_pkg::item_t              item_q;
  logic                           fire;
  logic [sv39pw_pkg::PPN_W-1:0]   root_q;
  sv39pw_pkg::phase_e             phase_q, phase_d;
  logic                           is_upd_q, is_upd_d;
  logic [sv39pw_pkg::VA_W-1:0]    vaddr_q, vaddr_d;
  logic [sv39pw_pkg::PPN_W-1:0]   tppn_q, tppn_d;
  logic [sv39pw_pkg::PERM_W-1:0]  perm_q, perm_d;
  logic [sv39pw_pkg::PA_W-1:0]    leaf_q, leaf_d;
  logic [sv39pw_pkg::PA_W-1:0]    nbase;
  logic [sv39pw_pkg::PA_W-1:0]    leaf_new;
  sv39pw_pkg::push_t              push;

  assign fire       = item_vld_q && room_i;
  assign in_ready_o = !item_vld_q || fire;
  assign item_vld_d = (in_valid_i && in_ready_o) ? 1'b1 : (fire ? 1'b0 : item_vld_q);

  assign nbase    = sv39pw_pkg::next_base(item_q.read_data);
  assign leaf_new = sv39pw_pkg::slot_addr(nbase, vaddr_q[20:12]);

  always_comb begin
    phase_d  = phase_q;
    is_upd_d = is_upd_q;
    vaddr_d  = vaddr_q;
    tppn_d   = tppn_q;
    perm_d   = perm_q;
    leaf_d   = leaf_q;
    push     = '0;
    if (fire) begin
      case (item_q.opcode)
        sv39pw_pkg::OP_LOOKUP, sv39pw_pkg::OP_UPDATE: begin
          if (phase_q == sv39pw_pkg::PH_IDLE) begin
            is_upd_d = (item_q.opcode == sv39pw_pkg::OP_UPDATE);
            vaddr_d  = item_q.virt_addr;
            tppn_d   = item_q.target_ppn;
            perm_d   = item_q.perm_bits;
            phase_d  = sv39pw_pkg::PH_L2;
            push.cnt          = 2'd1;
            push.r0.kind      = sv39pw_pkg::KIND_READ;
            push.r0.phys_addr = sv39pw_pkg::slot_addr({root_q, 12'h000},
                                                      item_q.virt_addr[38:30]);
            push.r0.last      = 1'b1;
          end
        end
        sv39pw_pkg::OP_RESP: begin
          case (phase_q)
            sv39pw_pkg::PH_L2, sv39pw_pkg::PH_L1: begin
              push.cnt     = 2'd1;
              push.r0.last = 1'b1;
              if (!item_q.read_data[0]) begin
                phase_d        = sv39pw_pkg::PH_IDLE;
                push.r0.kind   = sv39pw_pkg::KIND_FINISH;
                push.r0.status = sv39pw_pkg::ST_MISSING;
              end else if (|item_q.read_data[3:1]) begin
                phase_d        = sv39pw_pkg::PH_IDLE;
                push.r0.kind   = sv39pw_pkg::KIND_FINISH;
                push.r0.status = sv39pw_pkg::ST_SUPERPAGE;
              end else if (phase_q == sv39pw_pkg::PH_L2) begin
                phase_d           = sv39pw_pkg::PH_L1;
                push.r0.kind      = sv39pw_pkg::KIND_READ;
                push.r0.phys_addr = sv39pw_pkg::slot_addr(nbase, vaddr_q[29:21]);
              end else begin
                leaf_d            = leaf_new;
                push.r0.phys_addr = leaf_new;
                if (is_upd_q) begin
                  phase_d      = sv39pw_pkg::PH_LEAF;
                  push.r0.kind = sv39pw_pkg::KIND_READ;
                end else begin
                  phase_d      = sv39pw_pkg::PH_IDLE;
                  push.r0.kind = sv39pw_pkg::KIND_FINISH;
                end
              end
            end
            sv39pw_pkg::PH_LEAF: begin
              phase_d = sv39pw_pkg::PH_IDLE;
              push.r0.phys_addr = leaf_q;
              if (!item_q.read_data[0]) begin
                push.cnt       = 2'd1;
                push.r0.kind   = sv39pw_pkg::KIND_FINISH;
                push.r0.status = sv39pw_pkg::ST_LEAF_INV;
                push.r0.last   = 1'b1;
              end else begin
                // write the new leaf, then report completion
                push.cnt           = 2'd2;
                push.r0.kind       = sv39pw_pkg::KIND_WRITE;
                push.r0.write_data = {{(sv39pw_pkg::PTE_W-sv39pw_pkg::PPN_W
                                        -sv39pw_pkg::PERM_W){1'b0}}, tppn_q, perm_q};
                push.r1.kind       = sv39pw_pkg::KIND_FINISH;
                push.r1.phys_addr  = leaf_q;
                push.r1.status     = sv39pw_pkg::ST_OK;
                push.r1.last       = 1'b1;
              end
            end
            default: begin
              // idle: a stray response is dropped
            end
          endcase
        end
        default: begin
          // undefined opcode: dropped
        end
      endcase
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      root_q     <= '0;
      phase_q    <= sv39pw_pkg::PH_IDLE;
      is_upd_q   <= 1'b0;
      vaddr_q    <= '0;
      tppn_q     <= '0;
      perm_q     <= '0;
      leaf_q     <= '0;
    end else begin
      item_vld_q <= item_vld_d;
      if (cfg_we_i) begin
        root_q <= cfg_data_i;
      end
      phase_q  <= phase_d;
      is_upd_q <= is_upd_d;
      vaddr_q  <= vaddr_d;
      tppn_q   <= tppn_d;
      perm_q   <= perm_d;
      leaf_q   <= leaf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  `SV39PW_ASSERT_NOW(a_two_only_at_leaf, clk_i, rst_ni, fire && push.cnt == 2'd2,
                     phase_q == sv39pw_pkg::PH_LEAF)
  `SV39PW_ASSERT_NOW(a_idle_resp_dropped, clk_i, rst_ni,
                     fire && item_q.opcode == sv39pw_pkg::OP_RESP
                     && phase_q == sv39pw_pkg::PH_IDLE, push.cnt == 2'd0)
  `SV39PW_ASSERT_NEXT(a_req_starts_walk, clk_i, rst_ni,
                      fire && phase_q == sv39pw_pkg::PH_IDLE
                      && (item_q.opcode == sv39pw_pkg::OP_LOOKUP
                          || item_q.opcode == sv39pw_pkg::OP_UPDATE),
                      phase_q == sv39pw_pkg::PH_L2)
  `SV39PW_ASSERT_NEXT(a_stall_holds_item, clk_i, rst_ni, item_vld_q && !room_i,
                      item_vld_q && $stable(item_q))

endmodule

`default_nettype wire

// ----- rtl/core/sv39pw_outq.sv -----
// Result queue: takes up to two results a cycle, hands out one a cycle while the consumer is ready.
// Depends on sv39pw_pkg and the assertion macro header.
`default_nettype none
`include "sv39_page_walk_lookup_update_macros.svh"

module sv39pw_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sv39pw_pkg::push_t  push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sv39pw_pkg::res_t        out_res_o
);

  sv39pw_pkg::res_t                    entry_q [sv39pw_pkg::OUTQ_DEPTH];
  logic [sv39pw_pkg::OUTQ_PTR_W-1:0]   head_q, head_d;
  logic [sv39pw_pkg::OUTQ_PTR_W-1:0]   tail_q, tail_d;
  logic [sv39pw_pkg::OUTQ_PTR_W-1:0]   tail_p1;
  logic [sv39pw_pkg::OUTQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                                pop;

  // room for the largest burst one item can cause
  assign room_o      = cnt_q <= sv39pw_pkg::OUTQ_CNT_W'(sv39pw_pkg::OUTQ_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_res_o   = entry_q[head_q];
  assign pop         = out_valid_o && out_ready_i;
  assign tail_p1     = tail_q + 1'b1;

  assign head_d = head_q + sv39pw_pkg::OUTQ_PTR_W'(pop);
  assign tail_d = tail_q + sv39pw_pkg::OUTQ_PTR_W'(push_i.cnt);
  assign cnt_d  = cnt_q + sv39pw_pkg::OUTQ_CNT_W'(push_i.cnt)
                - sv39pw_pkg::OUTQ_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entry_q[tail_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      entry_q[tail_p1] <= push_i.r1;
    end
  end

  `SV39PW_ASSERT_NOW(a_push_has_room, clk_i, rst_ni, push_i.cnt != 2'd0, room_o)
  `SV39PW_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1,
                     cnt_q <= sv39pw_pkg::OUTQ_CNT_W'(sv39pw_pkg::OUTQ_DEPTH))
  `SV39PW_ASSERT_NEXT(a_pop_drains, clk_i, rst_ni, pop && push_i.cnt == 2'd0,
                      cnt_q == $past(cnt_q) - 1'b1)

endmodule

`default_nettype wire

// ----- rtl/core/sv39_page_walk_lookup_update.sv -----
// Top level of the Sv39 page walker (lookup and update).
// Depends on sv39pw_pkg, the three channel interfaces, sv39pw_step, sv39pw_outq.
//
//   channel   dir  payload                                          accepted when
//   in_bus    in   opcode, virt_addr, target_ppn, perm_bits, read   valid && ready
//   out_bus   out  kind, phys_addr, write_data, status, last        valid && ready
//   cfg_bus   in   data = root_table_ppn                            valid && ready
//
// One item per cycle while the result queue has room: an accepted item is held
// in the input register, its results are formed there and enter the result
// queue together. Results reach out_bus once the item has passed the input
// register and been written into the result queue, which drives out_bus directly.
// The 4-entry result queue admits an item only with two free slots, so an
// update completion (two results) can stall input under steady flow.
// Asynchronous active-low reset empties the queue and returns the walk to idle.
// cfg_bus is always ready; write it only while the walker is idle.
`default_nettype none

module sv39_page_walk_lookup_update (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  sv39pw_req_if.sink     in_bus,
  sv39pw_res_if.source   out_bus,
  sv39pw_cfg_if.sink     cfg_bus
);

  sv39pw_pkg::item_t  in_item;
  sv39pw_pkg::push_t  push;
  sv39pw_pkg::res_t   out_res;
  logic               room;
  logic               in_ready;
  logic               out_valid;

  assign in_item.opcode     = in_bus.opcode;
  assign in_item.virt_addr  = in_bus.virt_addr;
  assign in_item.target_ppn = in_bus.target_ppn;
  assign in_item.perm_bits  = in_bus.perm_bits;
  assign in_item.read_data  = in_bus.read_data;
  assign in_bus.ready       = in_ready;

  // root PPN register lives with the walk state
  assign cfg_bus.ready = 1'b1;

  sv39pw_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_bus.valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .cfg_we_i   (cfg_bus.valid),
    .cfg_data_i (cfg_bus.data),
    .room_i     (room),
    .push_o     (push)
  );

  sv39pw_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid),
    .out_ready_i (out_bus.ready),
    .out_res_o   (out_res)
  );

  assign out_bus.valid      = out_valid;
  assign out_bus.kind       = out_res.kind;
  assign out_bus.phys_addr  = out_res.phys_addr;
  assign out_bus.write_data = out_res.write_data;
  assign out_bus.status     = out_res.status;
  assign out_bus.last       = out_res.last;

endmodule

`default_nettype wire
